>>> design/lhs_pkg.sv
// ----------------------------------------------------------------------------
// lhs_pkg
// Shared types and constants of the link heartbeat supervisor.
// ----------------------------------------------------------------------------
package lhs_pkg;

   localparam int ACT_MAX     = 6;
   localparam int ACT_IDX_W   = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      ACT_NONE         = 4'd0,
      ACT_LINK_REQ     = 4'd1,
      ACT_HEARTBEAT    = 4'd2,
      ACT_REPORT       = 4'd3,
      ACT_WDOG_WARN    = 4'd4,
      ACT_POWER_DOWN   = 4'd5,
      ACT_TIMEOUT_WARN = 4'd6,
      ACT_SELF_RESET   = 4'd7,
      ACT_POWER_UP     = 4'd8,
      ACT_LINK_UP      = 4'd9,
      ACT_FEED_ACK     = 4'd10
   } action_type;

   typedef enum logic [2:0] {
      FUNC_TICK     = 3'd0,
      FUNC_LINK_ACK = 3'd1,
      FUNC_BEAT_ACK = 3'd2,
      FUNC_FEED     = 3'd3,
      FUNC_SLEEP    = 3'd4,
      FUNC_WAKE     = 3'd5
   } func_type;

   localparam logic [2:0] REG_HB_PERIOD    = 3'd0;
   localparam logic [2:0] REG_LINK_TIMEOUT = 3'd1;
   localparam logic [2:0] REG_FEED_RELOAD  = 3'd2;
   localparam logic [2:0] REG_EXP_RELOAD   = 3'd3;
   localparam logic [2:0] REG_PWR_DELAY    = 3'd4;

   localparam logic [15:0] RST_HB_PERIOD    = 16'd20;
   localparam logic [15:0] RST_LINK_TIMEOUT = 16'd600;
   localparam logic [15:0] RST_FEED_RELOAD  = 16'd30;
   localparam logic [15:0] RST_EXP_RELOAD   = 16'd600;
   localparam logic [3:0]  RST_PWR_DELAY    = 4'd3;
   localparam logic [15:0] RST_WDOG         = 16'd600;

   localparam logic [15:0] WDOG_WARN_AT   = 16'd10;
   localparam logic [16:0] TIMEOUT_MARGIN = 17'd10;
   localparam logic [7:0]  ACK_BYTE       = 8'h01;
   localparam logic [7:0]  FEED_BYTE      = 8'hAA;

   typedef struct packed {
      logic [15:0] hb_period;
      logic [15:0] link_timeout;
      logic [15:0] feed_reload;
      logic [15:0] expiry_reload;
      logic [3:0]  power_up_delay;
   } cfg_type;

   typedef struct packed {
      logic [ACT_MAX-1:0][3:0] acts;
      logic [ACT_IDX_W-1:0]    count;
      logic                    connected;
   } entry_type;

endpackage

>>> design/link_heartbeat_supervisor_unit.sv
// ----------------------------------------------------------------------------
// link_heartbeat_supervisor_unit
// Serial link supervisor: link request, heartbeat, watchdog and power control.
//
//   channel | dir | contents
//   req     | in  | tuser[2:0] func, tdata[7:0] data_byte
//   rsp     | out | tdata[3:0] action, tuser[0] connected, tlast last
//   csr     | in  | APB, 5 registers at 4*i
//
// One event is taken per cycle while the 4-entry queue has room.
// Each event yields 1 to 6 actions, sent one per cycle while rsp_tready
// is held high; every action passes through the single output register.
// First action is offered after the queue, current-entry and output registers.
// Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
module link_heartbeat_supervisor_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [2:0]  req_tuser,   // [2:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [3:0] action, [7:4] zero
   output logic [0:0]  rsp_tuser,   // [0] connected
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   lhs_pkg::cfg_type   cfg_ff;
   lhs_pkg::entry_type f_entry;
   lhs_pkg::entry_type q_data;
   logic               f_push;
   logic               q_full;
   logic               q_valid;
   logic               q_pop;
   logic [3:0]         b_action;
   logic               b_conn;
   logic               csr_wr;
   logic [2:0]         csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hb_period      <= lhs_pkg::RST_HB_PERIOD;
         cfg_ff.link_timeout   <= lhs_pkg::RST_LINK_TIMEOUT;
         cfg_ff.feed_reload    <= lhs_pkg::RST_FEED_RELOAD;
         cfg_ff.expiry_reload  <= lhs_pkg::RST_EXP_RELOAD;
         cfg_ff.power_up_delay <= lhs_pkg::RST_PWR_DELAY;
      end else if (csr_wr) begin
         case (csr_idx)
            lhs_pkg::REG_HB_PERIOD:    cfg_ff.hb_period      <= csr_pwdata[15:0];
            lhs_pkg::REG_LINK_TIMEOUT: cfg_ff.link_timeout   <= csr_pwdata[15:0];
            lhs_pkg::REG_FEED_RELOAD:  cfg_ff.feed_reload    <= csr_pwdata[15:0];
            lhs_pkg::REG_EXP_RELOAD:   cfg_ff.expiry_reload  <= csr_pwdata[15:0];
            lhs_pkg::REG_PWR_DELAY:    cfg_ff.power_up_delay <= csr_pwdata[3:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         lhs_pkg::REG_HB_PERIOD:    csr_prdata = {16'd0, cfg_ff.hb_period};
         lhs_pkg::REG_LINK_TIMEOUT: csr_prdata = {16'd0, cfg_ff.link_timeout};
         lhs_pkg::REG_FEED_RELOAD:  csr_prdata = {16'd0, cfg_ff.feed_reload};
         lhs_pkg::REG_EXP_RELOAD:   csr_prdata = {16'd0, cfg_ff.expiry_reload};
         lhs_pkg::REG_PWR_DELAY:    csr_prdata = {28'd0, cfg_ff.power_up_delay};
         default:                   csr_prdata = '0;
      endcase
   end

   lhs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (req_tvalid),
      .in_func  (req_tuser),
      .in_data  (req_tdata),
      .q_full   (q_full),
      .in_ready (req_tready),
      .push     (f_push),
      .entry    (f_entry)
   );

   lhs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data (f_entry),
      .pop       (q_pop),
      .full      (q_full),
      .valid     (q_valid),
      .data      (q_data)
   );

   lhs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_data        (q_data),
      .pop           (q_pop),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_action    (b_action),
      .out_connected (b_conn),
      .out_last      (rsp_tlast)
   );

   assign rsp_tdata = {4'd0, b_action};
   assign rsp_tuser = b_conn;

endmodule

>>> design/lhs_front.sv
// ----------------------------------------------------------------------------
// lhs_front
// Takes one event per cycle unless full; updates supervisor state, builds its action list.
// ----------------------------------------------------------------------------
module lhs_front (
   input  logic               clock,
   input  logic               reset,
   input  lhs_pkg::cfg_type   cfg,
   input  logic               in_valid,
   input  logic [2:0]         in_func,
   input  logic [7:0]         in_data,
   input  logic               q_full,
   output logic               in_ready,
   output logic               push,
   output lhs_pkg::entry_type entry
);

   logic        conn_ff, conn_in;
   logic        awake_ff, awake_in;
   logic        rep_ff, rep_in;
   logic [15:0] beat_ff, beat_in;
   logic [15:0] sil_ff, sil_in;
   logic [15:0] wd_ff, wd_in;
   logic [3:0]  pd_ff, pd_in;

   logic [lhs_pkg::ACT_MAX-1:0][3:0] acts;
   logic [lhs_pkg::ACT_IDX_W-1:0]    n_act;
   logic [3:0]  pd_dec;
   logic [3:0]  pd_load;
   logic [15:0] beat_inc;
   logic [15:0] wd_dec;
   logic [15:0] sil_inc;
   logic        wd_expired;

   assign in_ready = !q_full;
   assign push     = in_valid && in_ready;
   assign pd_load  = (cfg.power_up_delay == 4'd0) ? 4'd1 : cfg.power_up_delay;
   assign pd_dec   = pd_ff - 4'd1;
   assign beat_inc = beat_ff + 16'd1;
   assign wd_dec   = wd_ff - 16'd1;
   assign sil_inc  = sil_ff + 16'd1;

   always_comb begin
      conn_in    = conn_ff;
      awake_in   = awake_ff;
      rep_in     = rep_ff;
      beat_in    = beat_ff;
      sil_in     = sil_ff;
      wd_in      = wd_ff;
      pd_in      = pd_ff;
      acts       = '0;
      n_act      = '0;
      wd_expired = 1'b0;
      case (lhs_pkg::func_type'(in_func))
         lhs_pkg::FUNC_TICK: begin
            if (pd_ff != 4'd0) begin
               pd_in = pd_dec;
               if (pd_dec == 4'd0) begin
                  acts[n_act] = lhs_pkg::ACT_POWER_UP;
                  n_act = n_act + 3'd1;
               end
            end
            if (awake_ff) begin
               if (!conn_ff) begin
                  acts[n_act] = lhs_pkg::ACT_LINK_REQ;
                  n_act = n_act + 3'd1;
               end else begin
                  if (beat_inc >= cfg.hb_period) begin
                     beat_in = '0;
                     acts[n_act] = lhs_pkg::ACT_HEARTBEAT;
                     n_act = n_act + 3'd1;
                     if (!rep_ff) begin
                        acts[n_act] = lhs_pkg::ACT_REPORT;
                        n_act = n_act + 3'd1;
                        rep_in = 1'b1;
                     end
                  end else begin
                     beat_in = beat_inc;
                  end
                  if (wd_ff != 16'd0) begin
                     if (wd_dec == 16'd0) begin
                        wd_expired = 1'b1;
                        wd_in   = cfg.expiry_reload;
                        conn_in = 1'b0;
                        beat_in = '0;
                        sil_in  = '0;
                        pd_in   = pd_load;
                        acts[n_act] = lhs_pkg::ACT_POWER_DOWN;
                        n_act = n_act + 3'd1;
                     end else begin
                        wd_in = wd_dec;
                        if (wd_dec == lhs_pkg::WDOG_WARN_AT) begin
                           acts[n_act] = lhs_pkg::ACT_WDOG_WARN;
                           n_act = n_act + 3'd1;
                        end
                     end
                  end
               end
               if (!wd_expired) begin
                  if (sil_inc >= cfg.link_timeout) begin
                     conn_in = 1'b0;
                     beat_in = '0;
                     sil_in  = '0;
                     rep_in  = 1'b0;
                     pd_in   = pd_load;
                     acts[n_act] = lhs_pkg::ACT_POWER_DOWN;
                     n_act = n_act + 3'd1;
                     acts[n_act] = lhs_pkg::ACT_SELF_RESET;
                     n_act = n_act + 3'd1;
                  end else begin
                     sil_in = sil_inc;
                     if ({1'b0, sil_inc} + lhs_pkg::TIMEOUT_MARGIN
                         == {1'b0, cfg.link_timeout}) begin
                        acts[n_act] = lhs_pkg::ACT_TIMEOUT_WARN;
                        n_act = n_act + 3'd1;
                     end
                  end
               end
            end
         end
         lhs_pkg::FUNC_LINK_ACK: begin
            if (in_data == lhs_pkg::ACK_BYTE) begin
               beat_in = '0;
               sil_in  = '0;
               conn_in = 1'b1;
               acts[0] = lhs_pkg::ACT_LINK_UP;
               acts[1] = lhs_pkg::ACT_HEARTBEAT;
               n_act   = 3'd2;
            end
         end
         lhs_pkg::FUNC_BEAT_ACK: begin
            if (in_data == lhs_pkg::ACK_BYTE) begin
               beat_in = '0;
               sil_in  = '0;
               conn_in = 1'b1;
            end
         end
         lhs_pkg::FUNC_FEED: begin
            if (in_data == lhs_pkg::FEED_BYTE) begin
               wd_in   = cfg.feed_reload;
               acts[0] = lhs_pkg::ACT_FEED_ACK;
               n_act   = 3'd1;
            end
         end
         lhs_pkg::FUNC_SLEEP: begin
            awake_in = 1'b0;
            conn_in  = 1'b0;
            rep_in   = 1'b0;
         end
         lhs_pkg::FUNC_WAKE: begin
            awake_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      entry.acts      = acts;
      entry.count     = (n_act == 3'd0) ? 3'd1 : n_act;
      entry.connected = conn_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conn_ff  <= 1'b0;
         awake_ff <= 1'b0;
         rep_ff   <= 1'b0;
         beat_ff  <= '0;
         sil_ff   <= '0;
         wd_ff    <= lhs_pkg::RST_WDOG;
         pd_ff    <= '0;
      end else if (push) begin
         conn_ff  <= conn_in;
         awake_ff <= awake_in;
         rep_ff   <= rep_in;
         beat_ff  <= beat_in;
         sil_ff   <= sil_in;
         wd_ff    <= wd_in;
         pd_ff    <= pd_in;
      end
   end

endmodule

>>> design/lhs_queue.sv
// ----------------------------------------------------------------------------
// lhs_queue
// Short FIFO of action lists between the front and back parts.
// ----------------------------------------------------------------------------
module lhs_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lhs_pkg::entry_type push_data,
   input  logic               pop,
   output logic               full,
   output logic               valid,
   output lhs_pkg::entry_type data
);

   lhs_pkg::entry_type mem [lhs_pkg::QUEUE_DEPTH];
   logic [lhs_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [lhs_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [lhs_pkg::QCNT_W-1:0] cnt_ff, cnt_in;

   assign full  = (cnt_ff == lhs_pkg::QCNT_W'(lhs_pkg::QUEUE_DEPTH));
   assign valid = (cnt_ff != '0);
   assign data  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == lhs_pkg::QPTR_W'(lhs_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + lhs_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == lhs_pkg::QPTR_W'(lhs_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + lhs_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + lhs_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - lhs_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

>>> design/lhs_back.sv
// ----------------------------------------------------------------------------
// lhs_back
// Pops action lists and sends them out one action per transaction.
// ----------------------------------------------------------------------------
module lhs_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  lhs_pkg::entry_type q_data,
   output logic               pop,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [3:0]         out_action,
   output logic               out_connected,
   output logic               out_last
);

   logic                          cur_valid_ff, cur_valid_in;
   lhs_pkg::entry_type            cur_ff, cur_in;
   logic [lhs_pkg::ACT_IDX_W-1:0] idx_ff, idx_in;
   logic                          out_valid_ff, out_valid_in;
   logic [3:0]                    out_action_ff;
   logic                          out_conn_ff;
   logic                          out_last_ff;
   logic                          out_free;
   logic                          emit;
   logic                          is_last;

   assign out_free = !out_valid_ff || out_ready;
   assign emit     = cur_valid_ff && out_free;
   assign is_last  = (idx_ff == cur_ff.count - 3'd1);
   assign pop      = q_valid && (!cur_valid_ff || (emit && is_last));

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      if (emit) begin
         idx_in = idx_ff + 3'd1;
         if (is_last) begin
            cur_valid_in = 1'b0;
            idx_in       = '0;
         end
      end
      if (pop) begin
         cur_valid_in = 1'b1;
         cur_in       = q_data;
         idx_in       = '0;
      end
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         out_action_ff <= cur_ff.acts[idx_ff];
         out_conn_ff   <= cur_ff.connected;
         out_last_ff   <= is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign out_valid     = out_valid_ff;
   assign out_action    = out_action_ff;
   assign out_connected = out_conn_ff;
   assign out_last      = out_last_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (cur_ff.count != 3'd0) &&
                       (cur_ff.count <= 3'(lhs_pkg::ACT_MAX)))
      else $error("action count out of range");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> idx_ff < cur_ff.count)
      else $error("action index past count");

   a_last_restart: assert property (@(posedge clock) disable iff (reset)
      (emit && is_last) |=> (idx_ff == '0))
      else $error("index not restarted after last action");

   a_pop_room: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid && (!cur_valid_ff || emit))
      else $error("pop without room");

endmodule
